// File: hdl/concentration_feedback_factor_macros.svh
// Assertion macros shared by the concentration feedback factor modules.
`ifndef CONCENTRATION_FEEDBACK_FACTOR_MACROS_SVH
`define CONCENTRATION_FEEDBACK_FACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cff_pkg.sv
// Shared constants, codes and types of the concentration feedback factor.
package cff_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_EXPONENT_DEF = 15;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int CONC_W           = 32;
    localparam int EXP_W            = 4;
    localparam int EXP_LIMIT        = 15;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORM      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_MAX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT  = 3'd4;

    // Feedback sign codes
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_NEG  = 2'd1;
    localparam logic [1:0] SIGN_POS  = 2'd2;
    localparam logic [1:0] SIGN_RSVD = 2'd3;   // behaves as none

    // Curve form codes
    localparam logic [1:0] FORM_HYP  = 2'd0;
    localparam logic [1:0] FORM_INC  = 2'd1;
    localparam logic [1:0] FORM_DEC  = 2'd2;
    localparam logic [1:0] FORM_UNIT = 2'd3;   // ratio fixed at 1.0

    typedef enum logic [1:0] {
        RATIO_DIV  = 2'd0,
        RATIO_ONE  = 2'd1,
        RATIO_ZERO = 2'd2
    } ratio_sel_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic             active;
        ratio_sel_t       sel;
        logic [EXP_W-1:0] n;
        logic [CONC_W-1:0] num;
        logic [CONC_W:0]   den;
    } cff_job_t;

endpackage

// File: hdl/cff_if.sv
// Valid/ready channel interfaces for input and result words.
interface cff_in_if import cff_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CONC_W-1:0] concentration;

    modport source (output valid, output concentration, input ready);
    modport sink   (input valid, input concentration, output ready);
endinterface

interface cff_out_if import cff_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] factor;
    logic               modified;

    modport source (output valid, output factor, output modified, input ready);
    modport sink   (input valid, input factor, input modified, output ready);
endinterface

// File: hdl/cff_front.sv
// Front end: configuration registers and classification of input words.
module cff_front import cff_pkg::*; #(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [CONC_W-1:0]      conc,
    output cff_job_t               job
);

    logic [1:0]        sign_reg;
    logic [1:0]        form_reg;
    logic [CONC_W-1:0] thr_reg;
    logic [CONC_W-1:0] hm_reg;
    logic [EXP_W-1:0]  exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_reg <= SIGN_NONE;
            form_reg <= FORM_HYP;
            thr_reg  <= '0;
            hm_reg   <= '0;
            exp_reg  <= EXP_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                CFG_SIGN:      sign_reg <= cfg_wr_data[1:0];
                CFG_FORM:      form_reg <= cfg_wr_data[1:0];
                CFG_THRESHOLD: thr_reg  <= cfg_wr_data[CONC_W-1:0];
                CFG_HALF_MAX:  hm_reg   <= cfg_wr_data[CONC_W-1:0];
                CFG_EXPONENT:  exp_reg  <= cfg_wr_data[EXP_W-1:0];
                default:       ;
            endcase
        end
    end

    logic            neg;
    logic            pos;
    logic [CONC_W:0] sum;
    logic [EXP_W-1:0] n_sat;

    assign neg   = (sign_reg == SIGN_NEG) && (conc < thr_reg);
    assign pos   = (sign_reg == SIGN_POS) && (conc > thr_reg);
    assign sum   = {1'b0, conc} + {1'b0, hm_reg};
    assign n_sat = (int'(exp_reg) > MAX_EXPONENT) ? EXP_W'(MAX_EXPONENT) : exp_reg;

    always_comb
    begin
        job.active = neg || pos;
        job.n      = (neg || pos) ? n_sat : '0;
        job.sel    = RATIO_DIV;
        job.num    = conc;
        job.den    = sum;
        unique case (form_reg)
            FORM_HYP:
            begin
                job.num = neg ? conc : thr_reg;
                job.den = neg ? {1'b0, thr_reg} : {1'b0, conc};
            end
            FORM_INC:
            begin
                job.num = conc;
                job.den = sum;
            end
            FORM_DEC:
            begin
                job.num = hm_reg;
                job.den = sum;
            end
            default: job.sel = RATIO_ONE;
        endcase
        // zero divisor gives ratio zero
        if (form_reg != FORM_UNIT && job.den == '0)
        begin
            job.sel = RATIO_ZERO;
        end
    end

endmodule

// File: hdl/cff_queue.sv
// Short job queue between front and back.
module cff_queue import cff_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cff_job_t push_job,
    output logic     not_full,
    input  logic     pop,
    output logic     not_empty,
    output cff_job_t pop_job
);

`include "concentration_feedback_factor_macros.svh"

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    cff_job_t            mem [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign not_full  = (count_reg != CntW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(do_push) - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `CFF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CntW'(QUEUE_DEPTH), "queue overfilled")
    `CFF_ASSERT_NEXT(a_count_track, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

// File: hdl/cff_back.sv
// Back end: pipelined restoring divider followed by a power multiply chain.
module cff_back import cff_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  cff_job_t           job,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FRAC_BITS:0] out_factor,
    output logic               out_modified
);

`include "concentration_feedback_factor_macros.svh"

    localparam int QW        = FRAC_BITS + 1;
    localparam int PowStages = (MAX_EXPONENT < EXP_LIMIT) ? MAX_EXPONENT : EXP_LIMIT;
    localparam logic [QW-1:0] One = QW'(1) << FRAC_BITS;

    typedef struct packed {
        logic             valid;
        logic             active;
        ratio_sel_t       sel;
        logic [EXP_W-1:0] n;
        logic [CONC_W:0]  rem;
        logic [CONC_W:0]  den;
        logic [QW-1:0]    q;
    } div_t;

    typedef struct packed {
        logic             valid;
        logic             active;
        logic [EXP_W-1:0] n;
        logic [QW-1:0]    ratio;
        logic [QW-1:0]    fac;
    } pow_t;

    div_t div_in [QW];
    div_t div_next [QW];
    div_t div_reg [QW];
    pow_t pow_in [PowStages];
    pow_t pow_next [PowStages];
    pow_t pow_reg [PowStages];

    // whole pipe moves unless the last stage holds an untaken word
    assign advance = out_ready || !pow_reg[PowStages-1].valid;

    always_comb
    begin
        div_in[0].valid  = job_valid;
        div_in[0].active = job.active;
        div_in[0].sel    = job.sel;
        div_in[0].n      = job.n;
        div_in[0].rem    = {1'b0, job.num};
        div_in[0].den    = job.den;
        div_in[0].q      = '0;
    end

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_div
            logic [CONC_W+1:0] trial;
            logic [CONC_W+1:0] diff;
            logic              ge;

            if (i > 0)
            begin : g_link
                assign div_in[i] = div_reg[i-1];
            end

            // first step compares unshifted: quotient bit of weight one
            assign trial = (i == 0) ? {1'b0, div_in[i].rem} : {div_in[i].rem, 1'b0};
            assign diff  = trial - {1'b0, div_in[i].den};
            assign ge    = (trial >= {1'b0, div_in[i].den});

            always_comb
            begin
                div_next[i]     = div_in[i];
                div_next[i].rem = ge ? diff[CONC_W:0] : trial[CONC_W:0];
                div_next[i].q   = {div_in[i].q[QW-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_reg[i] <= '0;
                end
                else if (advance)
                begin
                    div_reg[i] <= div_next[i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        pow_in[0].valid  = div_reg[QW-1].valid;
        pow_in[0].active = div_reg[QW-1].active;
        pow_in[0].n      = div_reg[QW-1].n;
        pow_in[0].fac    = One;
        unique case (div_reg[QW-1].sel)
            RATIO_DIV:  pow_in[0].ratio = (div_reg[QW-1].q > One) ? One : div_reg[QW-1].q;
            RATIO_ONE:  pow_in[0].ratio = One;
            RATIO_ZERO: pow_in[0].ratio = '0;
            default:    pow_in[0].ratio = One;
        endcase
    end

    genvar j;
    generate
        for (j = 0; j < PowStages; j++)
        begin : g_pow
            logic [2*QW-1:0] prod;

            if (j > 0)
            begin : g_link
                assign pow_in[j] = pow_reg[j-1];
            end

            assign prod = pow_in[j].fac * pow_in[j].ratio;

            always_comb
            begin
                pow_next[j] = pow_in[j];
                if (pow_in[j].n > EXP_W'(j))
                begin
                    pow_next[j].fac = prod[FRAC_BITS +: QW];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pow_reg[j] <= '0;
                end
                else if (advance)
                begin
                    pow_reg[j] <= pow_next[j];
                end
            end
        end
    endgenerate

    assign out_valid    = pow_reg[PowStages-1].valid;
    assign out_factor   = pow_reg[PowStages-1].fac;
    assign out_modified = pow_reg[PowStages-1].active;

    `CFF_ASSERT_NOW(a_unmod_one, out_valid && !out_modified, out_factor == One, "unmodified word not 1.0")
    `CFF_ASSERT_NOW(a_factor_max, out_valid, out_factor <= One, "factor above 1.0")

endmodule

// File: hdl/concentration_feedback_factor.sv
// Top level of the concentration feedback factor block.
// Each input word (a Q16.16 concentration) yields one result word: a Q1.FRAC_BITS
// scaling factor and a modified flag. Words are accepted one per clock while the
// queue has room; each accepted word is stored in the queue, then passes through
// the one-bit-per-stage divider and the one-multiply-per-stage power chain, whose
// last stage is the output register. A stalled result freezes the whole arithmetic
// pipe; the two-entry queue between the classifying front end and the pipe holds up
// to two words before input ready drops.
// Configuration writes must only be issued while no word is in flight.
module concentration_feedback_factor import cff_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    cff_in_if.sink                 in_ch,
    cff_out_if.source              out_ch
);

    cff_job_t front_job;
    cff_job_t queue_job;
    logic     q_not_full;
    logic     q_not_empty;
    logic     pipe_advance;

    // front: config registers plus threshold test and divisor selection
    cff_front #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .conc         (in_ch.concentration),
        .job          (front_job)
    );

    assign in_ch.ready = q_not_full;

    // queue decouples input acceptance from pipe stalls
    cff_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .pop       (pipe_advance),
        .not_empty (q_not_empty),
        .pop_job   (queue_job)
    );

    // back: divider stages then power stages; last stage is the output register
    cff_back #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job          (queue_job),
        .advance      (pipe_advance),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_factor   (out_ch.factor),
        .out_modified (out_ch.modified)
    );

endmodule

// File: dv/tb_concentration_feedback_factor.sv
// Testbench for concentration_feedback_factor: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_concentration_feedback_factor;
    import cff_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int LATENCY    = 60;       // pipe depth is 32 at defaults, with margin
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [FB:0] factor;
        logic        modified;
    } factor_word_t;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    cff_in_if  in_ch ();
    cff_out_if out_ch ();

    concentration_feedback_factor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

    // Shadow of the block's registers, updated on every write.
    logic [1:0]  sh_sign;
    logic [1:0]  sh_form;
    logic [31:0] sh_thresh;
    logic [31:0] sh_half_max;
    logic [3:0]  sh_exp;

    logic [31:0]  conc_pending[$];     // words waiting for the driver
    factor_word_t factor_expected[$];  // predicted results in order

    int send_idle_pct;   // chance per cycle the sender holds back
    int recv_stall_pct;  // chance per cycle the receiver stalls
    logic        hold_start;
    int unsigned hold_left;
    int          mismatches;
    int unsigned cycles;

    // Q16 ratio num/den, truncated; zero divisor gives zero.
    function automatic logic [63:0] q_ratio(logic [63:0] num, logic [63:0] den);
        if (den == 0)
            return 64'd0;
        return (num << FB) / den;
    endfunction

    // Expected factor and flag for one concentration under the shadow config.
    function automatic factor_word_t feedback_predict(logic [31:0] conc);
        factor_word_t r;
        logic [63:0]  c;
        logic [63:0]  t;
        logic [63:0]  h;
        logic [63:0]  ratio;
        logic [63:0]  acc;
        logic         neg;
        logic         pos;
        int           n;
        c   = conc;
        t   = sh_thresh;
        h   = sh_half_max;
        acc = 64'd1 << FB;
        neg = (sh_sign == SIGN_NEG) && (c < t);
        pos = (sh_sign == SIGN_POS) && (c > t);
        if (neg || pos)
        begin
            case (sh_form)
                FORM_HYP: ratio = neg ? q_ratio(c, t) : q_ratio(t, c);
                FORM_INC: ratio = q_ratio(c, c + h);
                FORM_DEC: ratio = q_ratio(h, c + h);
                default:  ratio = 64'd1 << FB;   // unused form code: unity
            endcase
            if (ratio > (64'd1 << FB))
                ratio = 64'd1 << FB;
            n = (sh_exp > MAX_EXPONENT_DEF) ? MAX_EXPONENT_DEF : sh_exp;
            for (int i = 0; i < n; i++)
                acc = (acc * ratio) >> FB;
        end
        r.factor   = acc[FB:0];
        r.modified = neg || pos;
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Driver: offers pending words, records the prediction on each handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.concentration <= '0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                factor_expected.push_back(feedback_predict(in_ch.concentration));
                void'(conc_pending.pop_front());
            end
            if (conc_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid         <= 1'b1;
                in_ch.concentration <= conc_pending[0];
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        factor_word_t exp_w;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (factor_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected word factor=%0d modified=%0b",
                                 out_ch.factor, out_ch.modified);
                end
                else
                begin
                    exp_w = factor_expected.pop_front();
                    if (out_ch.factor !== exp_w.factor || out_ch.modified !== exp_w.modified)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: factor exp %0d got %0d, modified exp %0b got %0b",
                                     exp_w.factor, out_ch.factor, exp_w.modified,
                                     out_ch.modified);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && !hold_start &&
                            ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        case (idx)
            CFG_SIGN:      sh_sign     = data[1:0];
            CFG_FORM:      sh_form     = data[1:0];
            CFG_THRESHOLD: sh_thresh   = data;
            CFG_HALF_MAX:  sh_half_max = data;
            CFG_EXPONENT:  sh_exp      = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] sgn, logic [1:0] frm, logic [31:0] thr,
                              logic [31:0] hm, logic [3:0] ex);
        cfg_write(CFG_SIGN, sgn);
        cfg_write(CFG_FORM, frm);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_HALF_MAX, hm);
        cfg_write(CFG_EXPONENT, ex);
    endtask

    // Wait until every word went in and came back, then let the pipe empty.
    task automatic drain();
        while (conc_pending.size() != 0 || in_ch.valid || factor_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_idling(int s, int r);
        @(posedge clk);
        send_idle_pct  <= s;
        recv_stall_pct <= r;
    endtask

    // Concentrations clustered near the interesting points of the config.
    function automatic logic [31:0] pick_conc();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return sh_thresh + $urandom_range(64) - 32;
            2:       return $urandom_range(4095);
            3:       return sh_half_max + $urandom_range(1024) - 512;
            4:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            default: return sh_thresh >> $urandom_range(4);
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(4))
            0:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            1:       return $urandom();
            default: return $urandom_range(32'h00FF_FFFF);
        endcase
    endfunction

    initial
    begin
        int          sel;
        logic [31:0] c;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = '0;
        cfg_wr_data    = '0;
        in_ch.valid    = 1'b0;
        in_ch.concentration = '0;
        out_ch.ready   = 1'b0;
        hold_start     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        cycles         = 0;
        sh_sign = SIGN_NONE; sh_form = FORM_HYP; sh_thresh = 0; sh_half_max = 0; sh_exp = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: no feedback, factor is always one.
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'hFFFF_FFFF);
        drain();

        // Negative hyperbolic: below and equal to the threshold, max threshold.
        set_config(SIGN_NEG, FORM_HYP, 32'hFFFF_FFFF, 0, 1);
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'h8000_0000);
        conc_pending.push_back(32'hFFFF_FFFE);
        conc_pending.push_back(32'hFFFF_FFFF);
        drain();

        // Positive hyperbolic, zero threshold, largest exponent.
        set_config(SIGN_POS, FORM_HYP, 32'd0, 0, 15);
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'd1);
        conc_pending.push_back(32'hFFFF_FFFF);
        drain();

        // Sigmoid increase and decrease, including conc and half max both zero.
        set_config(SIGN_NEG, FORM_INC, 32'h0001_0000, 0, 2);
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'h0000_8000);
        drain();
        set_config(SIGN_NEG, FORM_DEC, 32'h0001_0000, 32'hFFFF_FFFF, 3);
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'h0000_FFFF);
        drain();
        cfg_write(CFG_HALF_MAX, 32'd0);
        conc_pending.push_back(32'd0);
        conc_pending.push_back(32'd5);
        drain();

        // Exponent zero, unused form code, unused sign code.
        set_config(SIGN_POS, FORM_DEC, 32'd100, 32'd50, 0);
        conc_pending.push_back(32'd200);
        conc_pending.push_back(32'd100);
        drain();
        cfg_write(CFG_FORM, 32'(FORM_UNIT));
        cfg_write(CFG_EXPONENT, 32'd4);
        conc_pending.push_back(32'd200);
        drain();
        cfg_write(CFG_SIGN, 32'(SIGN_RSVD));
        conc_pending.push_back(32'd200);
        conc_pending.push_back(32'd10);
        drain();

        // Random phases, rotating through the idling mixes.
        for (int ph = 0; ph < 12; ph++)
        begin
            sel = $urandom_range(9);
            set_config((sel < 4) ? SIGN_NEG : (sel < 8) ? SIGN_POS : 2'($urandom_range(3)),
                       ($urandom_range(9) == 0) ? FORM_UNIT : 2'($urandom_range(2)),
                       pick_level(), pick_level(),
                       ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(1, 4)));
            case (ph % 4)
                0:       set_idling(0, 0);
                1:       set_idling(83, 0);
                2:       set_idling(0, 83);
                default: set_idling(36, 36);
            endcase
            for (int k = 0; k < 100; k++)
            begin
                c = pick_conc();
                conc_pending.push_back(c);
            end
            // Receiver holds off while the sender keeps pushing: the block fills and stalls.
            if (ph == 4)
            begin
                @(posedge clk);
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            drain();
        end

        if (mismatches == 0 && factor_expected.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
